// ----- rtl/pivot_partition_records_assert.svh -----
// assertion helpers for the record partition block
`ifndef PIVOT_PARTITION_RECORDS_ASSERT_SVH
`define PIVOT_PARTITION_RECORDS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PPR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppr: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define PPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppr: next-cycle check failed");

`endif

// ----- rtl/ppr_pkg.sv -----
package ppr_pkg;

	localparam int IDX_W = 11;
	localparam int WORD_W = 64;
	localparam int TAG_W = 31;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_PART  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] key;
		logic [WORD_W-1:0]        second;
		logic [WORD_W-1:0]        third;
		logic [WORD_W-1:0]        fourth;
		logic [WORD_W-1:0]        weight;
		logic [TAG_W-1:0]         tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic [1:0]               action;
		logic [IDX_W-1:0]         position;
		logic signed [WORD_W-1:0] key;
		logic [WORD_W-1:0]        second_word;
		logic [WORD_W-1:0]        third_word;
		logic [WORD_W-1:0]        fourth_word;
		logic [WORD_W-1:0]        weight_word;
		logic [TAG_W-1:0]         order_tag;
		logic [IDX_W-1:0]         range_begin;
		logic [IDX_W-1:0]         range_end;
		logic signed [WORD_W-1:0] pivot;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] out_key;
		logic [WORD_W-1:0]        out_second;
		logic [WORD_W-1:0]        out_third;
		logic [WORD_W-1:0]        out_fourth;
		logic [WORD_W-1:0]        out_weight;
		logic [TAG_W-1:0]         out_tag;
		logic [IDX_W-1:0]         split_index;
	} out_item_t;

	typedef enum logic [1:0] {
		RA_POS,
		RA_BEG,
		RA_HI,
		RA_LO
	} rd_sel_t;

	typedef enum logic [2:0] {
		WS_INPUT,
		WS_PIVOT,
		WS_RDATA_LO,
		WS_RDATA_HI,
		WS_HOLD_LO
	} wr_sel_t;

	typedef enum logic [2:0] {
		RK_ZERO,
		RK_READ,
		RK_BEGM1,
		RK_SINGLE,
		RK_FINAL
	} res_kind_t;

	typedef struct packed {
		logic      ld_input;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		wr_sel_t   wr_sel;
		logic      cap_hold;
		logic      init_ptr;
		logic      hi_dec;
		logic      lo_inc;
		logic      res_load;
		res_kind_t res_kind;
		logic      in_loop;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic pos_ok;
		logic range_empty;
		logic range_oob;
		logic single;
		logic lo_eq_hi;
		logic lo_gt_hi;
		logic pv_lt_rdata;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/ppr_if.sv -----
interface ppr_in_if;
	import ppr_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ppr_out_if;
	import ppr_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pivot_partition_records.sv -----
// record store with in-place partition. each input word is one action: write a
// record to a 1-based slot, read a record back, or partition a 1-based inclusive
// slot range about a pivot key (signed q32.32) so keys not above the pivot come
// first, though a single-slot range splits on strict less-than; the result
// word carries the split index. records live in one single-port-read,
// single-port-write ram with registered read. a partition has setup and
// finish steps around a pointer walk over the range, in which every key
// probe is a ram read state followed by a compare state; a move hands the
// walk to the other pointer. one word is in flight at a time; the result
// register lets the next word be taken while the previous result is still
// waiting. unwritten slots read as unknown data; there is no clearing pass
// after reset. an unused action code gives a zero result word.
`include "pivot_partition_records_assert.svh"

module pivot_partition_records #(
	parameter int STORE_DEPTH = 1024
) (
	input logic       clk,
	input logic       arst_n,
	ppr_in_if.sink    in_ch,
	ppr_out_if.source out_ch
);
	import ppr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: decodes the action and walks the hole-moving loop
	ppr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// record ram, range pointers, held record and result register
	ppr_datapath #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_ch.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data)
	);

	// a taken word keeps the block busy for at least the next cycle
	`PPR_ASSERT_NEXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready)
	// a result is only loaded into a free output register
	`PPR_ASSERT_SAME(a_load_free, cmd.res_load, !out_ch.valid || out_ch.ready)
	// the hole pointers never cross while the loop runs
	`PPR_ASSERT_SAME(a_ptr_order, cmd.in_loop, !sts.lo_gt_hi)
endmodule

// ----- rtl/ppr_ram.sv -----
module ppr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/ppr_ctrl.sv -----
module ppr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ppr_pkg::sts_t sts,
	output ppr_pkg::cmd_t cmd
);
	import ppr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_HOLD,
		ST_HI_RD,
		ST_HI_CMP,
		ST_LO_RD,
		ST_LO_CMP,
		ST_FINISH,
		ST_RESULT
	} state_t;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		cmd = '0;
		cmd.rd_sel = RA_POS;
		cmd.wr_sel = WS_INPUT;
		cmd.res_kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_input = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_RESULT;
				kind_d = RK_ZERO;
				case (sts.act)
					ACT_WRITE: begin
						cmd.wr_en = sts.pos_ok;
						cmd.wr_sel = WS_INPUT;
					end
					ACT_READ: begin
						if (sts.pos_ok) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RA_POS;
							kind_d = RK_READ;
						end
					end
					ACT_PART: begin
						if (sts.range_empty || sts.range_oob) begin
							kind_d = RK_BEGM1;
						end else if (sts.single) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RA_BEG;
							kind_d = RK_SINGLE;
						end else begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RA_BEG;
							state_d = ST_HOLD;
						end
					end
					default: begin
						kind_d = RK_ZERO;
					end
				endcase
			end
			ST_HOLD: begin
				cmd.cap_hold = 1'b1;
				cmd.init_ptr = 1'b1;
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WS_PIVOT;
				state_d = ST_HI_RD;
			end
			ST_HI_RD: begin
				cmd.in_loop = 1'b1;
				if (sts.lo_eq_hi) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_HI;
					state_d = ST_HI_CMP;
				end
			end
			ST_HI_CMP: begin
				cmd.in_loop = 1'b1;
				if (sts.pv_lt_rdata) begin
					cmd.hi_dec = 1'b1;
					state_d = ST_HI_RD;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = WS_RDATA_LO;
					state_d = ST_LO_RD;
				end
			end
			ST_LO_RD: begin
				cmd.in_loop = 1'b1;
				if (sts.lo_eq_hi) begin
					state_d = ST_FINISH;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_LO;
					state_d = ST_LO_CMP;
				end
			end
			ST_LO_CMP: begin
				cmd.in_loop = 1'b1;
				if (!sts.pv_lt_rdata) begin
					cmd.lo_inc = 1'b1;
					state_d = ST_LO_RD;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = WS_RDATA_HI;
					state_d = ST_HI_RD;
				end
			end
			ST_FINISH: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WS_HOLD_LO;
				kind_d = RK_FINAL;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= RK_ZERO;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
		end
	end
endmodule

// ----- rtl/ppr_datapath.sv -----
module ppr_datapath #(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ppr_pkg::in_item_t   in_data,
	input  ppr_pkg::cmd_t       cmd,
	output ppr_pkg::sts_t       sts,
	output logic                out_valid,
	input  logic                out_ready,
	output ppr_pkg::out_item_t  out_data
);
	import ppr_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	in_item_t         in_q;
	rec_t             hold_q;
	logic [IDX_W-1:0] lo_q, hi_q;
	logic             out_valid_q;
	out_item_t        out_q;

	rec_t             rdata, wdata;
	logic [AW-1:0]    raddr, waddr;
	logic [IDX_W-1:0] ridx, widx;
	logic [IDX_W-1:0] beg_m1;
	out_item_t        res;

	assign beg_m1 = (in_q.range_begin == '0) ? '0 : in_q.range_begin - 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			RA_POS:  ridx = in_q.position;
			RA_BEG:  ridx = in_q.range_begin;
			RA_HI:   ridx = hi_q;
			RA_LO:   ridx = lo_q;
			default: ridx = lo_q;
		endcase
	end

	always_comb begin
		widx = lo_q;
		wdata = rdata;
		case (cmd.wr_sel)
			WS_INPUT: begin
				widx = in_q.position;
				wdata = '{key: in_q.key, second: in_q.second_word,
					third: in_q.third_word, fourth: in_q.fourth_word,
					weight: in_q.weight_word, tag: in_q.order_tag};
			end
			WS_PIVOT: begin
				// slot is always overwritten later; only its key matters
				widx = in_q.range_begin;
				wdata = rdata;
				wdata.key = in_q.pivot;
			end
			WS_RDATA_LO: begin
				widx = lo_q;
				wdata = rdata;
			end
			WS_RDATA_HI: begin
				widx = hi_q;
				wdata = rdata;
			end
			WS_HOLD_LO: begin
				widx = lo_q;
				wdata = hold_q;
			end
			default: begin
				widx = lo_q;
				wdata = rdata;
			end
		endcase
	end

	// 1-based slot to 0-based address
	assign raddr = AW'(32'(ridx) - 32'd1);
	assign waddr = AW'(32'(widx) - 32'd1);

	ppr_ram #(
		.WIDTH(REC_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		res = '0;
		case (cmd.res_kind)
			RK_ZERO: res = '0;
			RK_READ: begin
				res.out_key = rdata.key;
				res.out_second = rdata.second;
				res.out_third = rdata.third;
				res.out_fourth = rdata.fourth;
				res.out_weight = rdata.weight;
				res.out_tag = rdata.tag;
			end
			RK_BEGM1: res.split_index = beg_m1;
			RK_SINGLE: begin
				res.split_index = (rdata.key < in_q.pivot) ? in_q.range_begin : beg_m1;
			end
			RK_FINAL: begin
				res.split_index = (in_q.pivot < hold_q.key) ? lo_q - 1'b1 : lo_q;
			end
			default: res = '0;
		endcase
	end

	assign sts.act = act_t'(in_q.action);
	assign sts.pos_ok = (in_q.position != '0) && (32'(in_q.position) <= STORE_DEPTH);
	assign sts.range_empty = in_q.range_end < in_q.range_begin;
	assign sts.range_oob = (in_q.range_begin == '0) || (32'(in_q.range_end) > STORE_DEPTH);
	assign sts.single = in_q.range_begin == in_q.range_end;
	assign sts.lo_eq_hi = lo_q == hi_q;
	assign sts.lo_gt_hi = lo_q > hi_q;
	assign sts.pv_lt_rdata = in_q.pivot < rdata.key;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.ld_input) begin
			in_q <= in_data;
		end
		if (cmd.cap_hold) begin
			hold_q <= rdata;
		end
		if (cmd.res_load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init_ptr) begin
				lo_q <= in_q.range_begin;
				hi_q <= in_q.range_end;
			end else begin
				if (cmd.lo_inc) begin
					lo_q <= lo_q + 1'b1;
				end
				if (cmd.hi_dec) begin
					hi_q <= hi_q - 1'b1;
				end
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

// ----- bench/pivot_partition_records_tb.sv -----
module pivot_partition_records_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppr_pkg::*;

	localparam int DEPTH = 1024;
	localparam int WINDOW = 128;            // slots used by the mixed random traffic
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ppr_in_if  in_ch ();
	ppr_out_if out_ch ();

	pivot_partition_records uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	// shadow copy of the record store, 1-based like the block's slots
	rec_t      shadow_rec [1:DEPTH];
	bit        slot_loaded [1:DEPTH];
	out_item_t pending_results [$];

	int  error_count = 0;
	int  words_sent = 0;
	int  words_checked = 0;
	int  partitions_sent = 0;
	int  cycle_count = 0;
	bit  idle_on = 1'b1;                    // sender gaps on or off for a stretch

	// ---------------------------------------------------------------
	// shadow model of the block
	// ---------------------------------------------------------------

	function automatic bit key_below(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

	// hole-moving partition on the shadow store, returns the split slot
	function automatic int shadow_partition(int first, int last, logic [WORD_W-1:0] pv);
		rec_t held;
		int lo;
		int hi;
		int split;
		if (last < first)
			return first - 1;
		if (first == 0 || last > DEPTH)
			return (first == 0) ? 0 : first - 1;
		if (first == last)
			return key_below(shadow_rec[first].key, pv) ? first : first - 1;
		// first record is set aside, the pivot key sits in its slot as the hole
		held = shadow_rec[first];
		shadow_rec[first].key = pv;
		lo = first;
		hi = last;
		while (lo != hi) begin
			while (lo < hi && key_below(pv, shadow_rec[hi].key))
				hi--;
			if (lo != hi)
				shadow_rec[lo] = shadow_rec[hi];
			while (lo < hi && !key_below(pv, shadow_rec[lo].key))
				lo++;
			if (lo != hi)
				shadow_rec[hi] = shadow_rec[lo];
		end
		split = key_below(pv, held.key) ? lo - 1 : lo;
		shadow_rec[lo] = held;
		return split;
	endfunction

	function automatic out_item_t shadow_step(in_item_t w);
		out_item_t r;
		int pos;
		r = '0;
		pos = int'(w.position);
		case (act_t'(w.action))
			ACT_WRITE: begin
				if (pos >= 1 && pos <= DEPTH) begin
					shadow_rec[pos].key    = w.key;
					shadow_rec[pos].second = w.second_word;
					shadow_rec[pos].third  = w.third_word;
					shadow_rec[pos].fourth = w.fourth_word;
					shadow_rec[pos].weight = w.weight_word;
					shadow_rec[pos].tag    = w.order_tag;
					slot_loaded[pos] = 1'b1;
				end
			end
			ACT_PART: begin
				r.split_index = IDX_W'(shadow_partition(int'(w.range_begin),
					int'(w.range_end), w.pivot));
			end
			ACT_READ: begin
				if (pos >= 1 && pos <= DEPTH) begin
					r.out_key    = shadow_rec[pos].key;
					r.out_second = shadow_rec[pos].second;
					r.out_third  = shadow_rec[pos].third;
					r.out_fourth = shadow_rec[pos].fourth;
					r.out_weight = shadow_rec[pos].weight;
					r.out_tag    = shadow_rec[pos].tag;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// word construction
	// ---------------------------------------------------------------

	// 64-bit value, biased toward extremes and a narrow key set for duplicates
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7FFF_FFFF_FFFF_FFFF;
			2: return 64'd0;
			3, 4: return {WORD_W'($signed($urandom_range(0, 6)) - 3)} << 32;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// every field random, so unused fields still toggle all their bits
	function automatic in_item_t noise_word();
		in_item_t w;
		w.action      = 2'($urandom);
		w.position    = IDX_W'($urandom);
		w.key         = {$urandom, $urandom};
		w.second_word = {$urandom, $urandom};
		w.third_word  = {$urandom, $urandom};
		w.fourth_word = {$urandom, $urandom};
		w.weight_word = {$urandom, $urandom};
		w.order_tag   = TAG_W'($urandom);
		w.range_begin = IDX_W'($urandom);
		w.range_end   = IDX_W'($urandom);
		w.pivot       = {$urandom, $urandom};
		return w;
	endfunction

	function automatic in_item_t write_word(int pos, logic [WORD_W-1:0] k);
		in_item_t w;
		w = noise_word();
		w.action = ACT_WRITE;
		w.position = IDX_W'(pos);
		w.key = k;
		return w;
	endfunction

	function automatic in_item_t read_word(int pos);
		in_item_t w;
		w = noise_word();
		w.action = ACT_READ;
		w.position = IDX_W'(pos);
		return w;
	endfunction

	function automatic in_item_t part_word(int first, int last, logic [WORD_W-1:0] pv);
		in_item_t w;
		w = noise_word();
		w.action = ACT_PART;
		w.range_begin = IDX_W'(first);
		w.range_end = IDX_W'(last);
		w.pivot = pv;
		return w;
	endfunction

	// pivot drawn from a key in the range half the time, so splits land inside
	function automatic logic [WORD_W-1:0] range_pivot(int first, int last);
		if ($urandom_range(0, 1) == 0)
			return shadow_rec[$urandom_range(first, last)].key;
		return pick_word();
	endfunction

	// ---------------------------------------------------------------
	// sender: one word per call, random gap before it
	// ---------------------------------------------------------------

	task automatic send_word(in_item_t w);
		int gap;
		out_item_t exp_res;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.data = w;
		do
			@(posedge clk);
		while (!in_ch.ready);
		// accepted at this edge, result must come later
		exp_res = shadow_step(w);
		pending_results.push_back(exp_res);
		words_sent++;
		if (act_t'(w.action) == ACT_PART)
			partitions_sent++;
	endtask

	// ---------------------------------------------------------------
	// result side: random stall per word when gaps are on, check at each accept
	// ---------------------------------------------------------------

	bit result_taken = 1'b0;

	initial begin
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (result_taken) begin
				stall = idle_on ? $urandom_range(0, 8) : 0;
				result_taken = 1'b0;
			end
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				stall--;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	task automatic compare_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			result_taken = 1'b1;
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing pending, actual %h", $time, got);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("out_key", want.out_key, got.out_key);
				compare_field("out_second", want.out_second, got.out_second);
				compare_field("out_third", want.out_third, got.out_third);
				compare_field("out_fourth", want.out_fourth, got.out_fourth);
				compare_field("out_weight", want.out_weight, got.out_weight);
				compare_field("out_tag", WORD_W'(want.out_tag), WORD_W'(got.out_tag));
				compare_field("split_index", WORD_W'(want.split_index),
					WORD_W'(got.split_index));
				words_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// extremes, each action, and the single, empty and out-of-bounds ranges
	task automatic test_directed();
		send_word(write_word(1, 64'h8000_0000_0000_0000));
		send_word(write_word(2, 64'h7FFF_FFFF_FFFF_FFFF));
		send_word(write_word(3, 64'd0));
		send_word(write_word(DEPTH, 64'hFFFF_FFFF_0000_0000));
		send_word(write_word(DEPTH - 1, 64'h0000_0001_8000_0000));
		send_word(read_word(1));
		send_word(read_word(DEPTH));
		// bad positions: write dropped, read gives zeros
		send_word(write_word(0, 64'h1234));
		send_word(write_word(DEPTH + 1, 64'h5678));
		send_word(read_word(0));
		send_word(read_word(2047));
		// unused action code
		begin
			in_item_t w;
			w = noise_word();
			w.action = ACT_NONE;
			send_word(w);
		end
		// single slot: strict less-than against the pivot
		send_word(part_word(2, 2, 64'h7FFF_FFFF_FFFF_FFFF));
		send_word(part_word(1, 1, 64'h8000_0000_0000_0000));
		send_word(part_word(3, 3, 64'd1));
		// empty ranges
		send_word(part_word(5, 4, pick_word()));
		send_word(part_word(2047, 0, pick_word()));
		// out of bounds, begin not above end
		send_word(part_word(0, 3, pick_word()));
		send_word(part_word(1000, 2047, pick_word()));
		// real partitions, including the top slot
		send_word(part_word(1, 3, 64'd0));
		send_word(part_word(DEPTH - 1, DEPTH, 64'd0));
		send_word(read_word(1));
		send_word(read_word(3));
		send_word(read_word(DEPTH - 1));
	endtask

	// load the random window so every slot in it is defined
	task automatic test_window_fill();
		for (int s = 1; s <= WINDOW; s++)
			send_word(write_word(s, pick_word()));
	endtask

	// mixed traffic in the window, mostly real partitions and reads
	task automatic test_window_random(int count);
		int first;
		int last;
		in_item_t w;
		for (int n = 0; n < count; n++) begin
			if (n % 150 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: send_word(write_word($urandom_range(1, WINDOW), pick_word()));
				5, 6, 7, 8, 9: send_word(read_word($urandom_range(1, WINDOW)));
				10, 11, 12, 13, 14, 15, 16: begin
					first = $urandom_range(1, WINDOW);
					last = ($urandom_range(0, 3) == 0) ? first :
						$urandom_range(first, (first + 40 > WINDOW) ? WINDOW : first + 40);
					send_word(part_word(first, last, range_pivot(first, last)));
				end
				17: begin
					// empty or out-of-bounds range
					first = $urandom_range(0, 2047);
					last = (first == 0) ? $urandom_range(0, 2047) :
						($urandom_range(0, 1) ? $urandom_range(0, first - 1) :
						$urandom_range(DEPTH + 1, 2047));
					if (last < first || first == 0 || last > DEPTH)
						send_word(part_word(first, last, pick_word()));
				end
				18: begin
					w = $urandom_range(0, 1) ? read_word($urandom_range(DEPTH + 1, 2047))
						: write_word($urandom_range(DEPTH + 1, 2047), pick_word());
					send_word(w);
				end
				default: begin
					w = noise_word();
					w.action = ACT_NONE;
					send_word(w);
				end
			endcase
		end
		idle_on = 1'b1;
	endtask

	// load the rest of the store and partition large spans, up to the whole store
	task automatic test_full_store();
		int first;
		for (int s = WINDOW + 1; s <= DEPTH; s++)
			if (!slot_loaded[s] || $urandom_range(0, 1))
				send_word(write_word(s, pick_word()));
		send_word(part_word(1, DEPTH, range_pivot(1, DEPTH)));
		send_word(part_word(1, DEPTH, 64'h7FFF_FFFF_FFFF_FFFF));
		for (int n = 0; n < 4; n++) begin
			first = $urandom_range(1, DEPTH - 300);
			send_word(part_word(first, first + $urandom_range(100, 299),
				range_pivot(first, DEPTH)));
		end
		for (int n = 0; n < 40; n++)
			send_word(read_word($urandom_range(1, DEPTH)));
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_window_fill();
		test_window_random(900);
		test_full_store();

		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sent %0d words (%0d partitions), checked %0d results",
			words_sent, partitions_sent, words_checked);
		$display("covered writes, reads, bad slots, empty, single and full-store ranges");
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
